FILE: hw/rtl/friction_traction_return_map_assert.svh
`ifndef FRICTION_TRACTION_RETURN_MAP_ASSERT_SVH
`define FRICTION_TRACTION_RETURN_MAP_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define FTRM_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define FTRM_IMPLIES(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ftrm_pkg.sv
package ftrm_pkg;

  // Register map
  localparam logic REG_TIME_STEP = 1'b0;

  // Pipeline shape
  localparam int SQ_STAGES  = 16;
  localparam int DIV_STAGES = 16;
  localparam int LANES      = 3;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] quo;
  } div_t;

  // Flags and stick-path traction carried alongside the scaling datapath
  typedef struct packed {
    logic             contact;
    logic             slide;
    logic [2:0]       neg;
    logic [2:0][31:0] stick_trac;
  } side_t;

  // One restoring square-root step: bring in two radicand bits
  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [1:0] pair);
    logic [35:0] r;
    logic [35:0] t;
    logic [35:0] d;
    sqrt_t       o;
    r = {s.rem, pair};
    t = {2'b00, s.root, 2'b01};
    d = r - t;
    if (r >= t) begin
      o.rem  = d[33:0];
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = r[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // One restoring division step: bring in one dividend bit
  function automatic div_t div_step(input div_t s, input logic b, input logic [31:0] nrm);
    logic [32:0] r;
    logic [32:0] n;
    div_t        o;
    r = {s.rem[31:0], b};
    n = {1'b0, nrm};
    if (r >= n) begin
      o.rem = r - n;
      o.quo = {s.quo[30:0], 1'b1};
    end else begin
      o.rem = r;
      o.quo = {s.quo[30:0], 1'b0};
    end
    return o;
  endfunction

  // Saturate a sign and magnitude to signed 32 bits
  function automatic logic [31:0] sat_out(input logic neg, input logic [48:0] mag);
    logic [31:0] res;
    if (neg) begin
      if (mag >= 49'h0_8000_0000) res = 32'h8000_0000;
      else res = ~mag[31:0] + 32'd1;
    end else begin
      if (mag >= 49'h0_7FFF_FFFF) res = 32'h7FFF_FFFF;
      else res = mag[31:0];
    end
    return res;
  endfunction

  // Smallest right shift that brings the value below 2^31
  function automatic logic [4:0] lead_shift(input logic [48:0] m);
    logic [4:0] k;
    k = 5'd0;
    for (int i = 31; i < 49; i++) begin
      if (m[i]) k = 5'(i - 30);
    end
    return k;
  endfunction

endpackage

FILE: hw/rtl/friction_traction_return_map.sv
// Channel  Handshake            Payload
// input    in_valid / in_ready  in_contact, impedance, strength, vel_*, acc_*, old_acc_*
// output   out_valid / out_ready trac_x, trac_y, trac_z, sticking
// config   APB write/read       time_step at byte address 0
//
// One node enters per cycle while the output register is empty or being taken.
// Each node passes through the 16-stage square-root pipe and the 16-stage divider
// lanes, each retiring two bits per stage.
// rst clears the valid bits, out_valid among them, and time_step; output data is not reset.
// A full output register that is not taken stalls the whole pipe at once.
module friction_traction_return_map (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_contact,
  input  logic [31:0] impedance,
  input  logic [31:0] strength,
  input  logic [31:0] vel_x,
  input  logic [31:0] vel_y,
  input  logic [31:0] vel_z,
  input  logic [31:0] acc_x,
  input  logic [31:0] acc_y,
  input  logic [31:0] acc_z,
  input  logic [31:0] old_acc_x,
  input  logic [31:0] old_acc_y,
  input  logic [31:0] old_acc_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] trac_x,
  output logic [31:0] trac_y,
  output logic [31:0] trac_z,
  output logic        sticking
);
  import ftrm_pkg::*;

  logic        adv;
  logic [31:0] time_step;
  logic [31:0] vin [LANES];
  logic [31:0] ain [LANES];
  logic [31:0] oin [LANES];

  // Stage 1: acceleration products
  logic        v1, c1;
  logic [31:0] imp1, str1;
  logic [31:0] vel1 [LANES];
  logic [63:0] pa1 [LANES];
  logic [63:0] po1 [LANES];
  // Stage 2: gap-rate magnitude
  logic        v2, c2;
  logic [31:0] imp2, str2;
  logic [33:0] m2 [LANES];
  logic [2:0]  neg2;
  // Stage 3: impedance partial products
  logic        v3, c3;
  logic [31:0] str3;
  logic [48:0] ph3 [LANES];
  logic [48:0] pl3 [LANES];
  logic [2:0]  neg3;
  // Stage 4: trial traction magnitude
  logic        v4, c4;
  logic [31:0] str4;
  logic [48:0] mag4 [LANES];
  logic [2:0]  neg4;
  // Stage 5: squares and maximum
  logic        v5, c5, big5;
  logic [31:0] str5;
  logic [63:0] strsq5;
  logic [63:0] sq5 [LANES];
  logic [48:0] mag5 [LANES];
  logic [48:0] max5;
  logic [2:0]  neg5;
  // Stage 6: slide decision and normalizing shift
  logic        v6;
  logic [31:0] str6;
  logic [4:0]  k6;
  logic [48:0] mag6 [LANES];
  side_t       side6;
  // Stage 7: shifted magnitudes
  logic        v7;
  logic [31:0] str7;
  logic [30:0] sm7 [LANES];
  side_t       side7;
  // Square-root pipe (index 0 holds squares summed, dividends formed)
  logic              sqv    [SQ_STAGES+1];
  side_t             sqside [SQ_STAGES+1];
  logic [63:0]       sqx    [SQ_STAGES+1];
  sqrt_t             sqst   [SQ_STAGES+1];
  logic [2:0][62:0]  sqdvd  [SQ_STAGES+1];
  // Divider lanes
  logic              dvi_v    [DIV_STAGES];
  side_t             dvi_side [DIV_STAGES];
  logic [31:0]       dvi_nrm  [DIV_STAGES];
  logic [2:0][31:0]  dvi_lo   [DIV_STAGES];
  div_t              dvi_st   [DIV_STAGES][LANES];
  logic              dvv      [1:DIV_STAGES];
  side_t             dvside   [1:DIV_STAGES];
  logic [31:0]       dvnrm    [1:DIV_STAGES];
  logic [2:0][31:0]  dvlo     [1:DIV_STAGES];
  div_t              dvst     [1:DIV_STAGES][LANES];
  // Output
  logic [2:0][31:0]  trac_next;
  logic              stick_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIME_STEP) ? time_step : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 32'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIME_STEP) begin
      time_step <= pwdata;
    end
  end

  assign vin[0] = vel_x;     assign vin[1] = vel_y;     assign vin[2] = vel_z;
  assign ain[0] = acc_x;     assign ain[1] = acc_y;     assign ain[2] = acc_z;
  assign oin[0] = old_acc_x; assign oin[1] = old_acc_y; assign oin[2] = old_acc_z;

  // Valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; sqv[0] <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6; sqv[0] <= v7;
    end
  end

  // Front datapath: gap rate, trial traction, slide test, scaling prep
  always_ff @(posedge clk) begin
    logic signed [64:0] pa;
    logic signed [64:0] po;
    logic [50:0]        g;
    logic [34:0]        g16;
    logic [34:0]        gneg;
    logic [49:0]        q;
    logic [65:0]        sum;
    logic [63:0]        ssum;
    logic [48:0]        mx;
    if (adv) begin
      // multiply accelerations by the time step
      c1 <= in_contact; imp1 <= impedance; str1 <= strength;
      for (int d = 0; d < LANES; d++) begin
        pa = $signed(ain[d]) * $signed({1'b0, time_step});
        po = $signed(oin[d]) * $signed({1'b0, time_step});
        vel1[d] <= vin[d];
        pa1[d]  <= pa[63:0];
        po1[d]  <= po[63:0];
      end
      // sum to the gap rate, floor to Q.16, take magnitude
      c2 <= c1; imp2 <= imp1; str2 <= str1;
      for (int d = 0; d < LANES; d++) begin
        g = {{3{vel1[d][31]}}, vel1[d], 16'd0} + {{3{pa1[d][63]}}, pa1[d][63:16]}
            - {{4{po1[d][63]}}, po1[d][63:17]};
        g16 = g[50:16];
        gneg = ~g16 + 35'd1;
        neg2[d] <= g16[34];
        m2[d]   <= g16[34] ? gneg[33:0] : g16[33:0];
      end
      // impedance times magnitude, split in two halves
      c3 <= c2; str3 <= str2; neg3 <= neg2;
      for (int d = 0; d < LANES; d++) begin
        ph3[d] <= 49'(imp2) * 49'(m2[d][33:17]);
        pl3[d] <= 49'(imp2) * 49'(m2[d][16:0]);
      end
      // join halves: floor(impedance * m / 2^17)
      c4 <= c3; str4 <= str3; neg4 <= neg3;
      for (int d = 0; d < LANES; d++) begin
        q = 50'(ph3[d]) + 50'(pl3[d][48:17]);
        mag4[d] <= q[48:0];
      end
      // squares, strength squared, maximum
      c5 <= c4; str5 <= str4; neg5 <= neg4;
      strsq5 <= 64'(str4) * 64'(str4);
      mx = 49'd0;
      for (int d = 0; d < LANES; d++) begin
        sq5[d]  <= 64'(mag4[d][31:0]) * 64'(mag4[d][31:0]);
        mag5[d] <= mag4[d];
        if (mag4[d] > mx) mx = mag4[d];
      end
      max5 <= mx;
      big5 <= |mx[48:32];
      // slide test, normalizing shift, stick-path saturation
      sum = 66'(sq5[0]) + 66'(sq5[1]) + 66'(sq5[2]);
      str6 <= str5;
      k6   <= lead_shift(max5);
      side6.contact <= c5;
      side6.slide   <= big5 || (sum > 66'(strsq5));
      side6.neg     <= neg5;
      for (int d = 0; d < LANES; d++) begin
        mag6[d] <= mag5[d];
        side6.stick_trac[d] <= sat_out(neg5[d], mag5[d]);
      end
      // shift all magnitudes by the common amount
      str7 <= str6; side7 <= side6;
      for (int d = 0; d < LANES; d++) begin
        mx = mag6[d] >> k6;
        sm7[d] <= mx[30:0];
      end
      // squared norm and scaled dividends
      ssum = 64'd0;
      for (int d = 0; d < LANES; d++) begin
        ssum = ssum + 64'(sm7[d]) * 64'(sm7[d]);
        sqdvd[0][d] <= 63'(sm7[d]) * 63'(str7);
      end
      sqx[0]    <= ssum;
      sqst[0]   <= '0;
      sqside[0] <= side7;
    end
  end

  // Square-root pipe, two result bits per stage
  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sqrt
    sqrt_t st_a;
    sqrt_t st_b;
    always_comb begin
      st_a = sqrt_step(sqst[s], sqx[s][63:62]);
      st_b = sqrt_step(st_a, sqx[s][61:60]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[s+1] <= 1'b0;
      end else if (adv) begin
        sqv[s+1] <= sqv[s];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sqst[s+1]   <= st_b;
        sqx[s+1]    <= {sqx[s][59:0], 4'd0};
        sqside[s+1] <= sqside[s];
        sqdvd[s+1]  <= sqdvd[s];
      end
    end
  end

  // Divider lanes, two quotient bits per stage
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    if (s == 0) begin : g_head
      assign dvi_v[s]    = sqv[SQ_STAGES];
      assign dvi_side[s] = sqside[SQ_STAGES];
      assign dvi_nrm[s]  = sqst[SQ_STAGES].root;
      for (genvar d = 0; d < LANES; d++) begin : g_ld
        assign dvi_lo[s][d]     = sqdvd[SQ_STAGES][d][31:0];
        assign dvi_st[s][d].rem = {2'b00, sqdvd[SQ_STAGES][d][62:32]};
        assign dvi_st[s][d].quo = 32'd0;
      end
    end else begin : g_body
      assign dvi_v[s]    = dvv[s];
      assign dvi_side[s] = dvside[s];
      assign dvi_nrm[s]  = dvnrm[s];
      assign dvi_lo[s]   = dvlo[s];
      for (genvar d = 0; d < LANES; d++) begin : g_ld
        assign dvi_st[s][d] = dvst[s][d];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[s+1] <= 1'b0;
      end else if (adv) begin
        dvv[s+1] <= dvi_v[s];
      end
    end
    always_ff @(posedge clk) begin
      div_t t;
      if (adv) begin
        dvside[s+1] <= dvi_side[s];
        dvnrm[s+1]  <= dvi_nrm[s];
        for (int d = 0; d < LANES; d++) begin
          t = div_step(dvi_st[s][d], dvi_lo[s][d][31], dvi_nrm[s]);
          t = div_step(t, dvi_lo[s][d][30], dvi_nrm[s]);
          dvst[s+1][d] <= t;
          dvlo[s+1][d] <= {dvi_lo[s][d][29:0], 2'b00};
        end
      end
    end
  end

  // Pick the result: zero out of contact or for a zero norm, sticking, or scaled back to strength
  always_comb begin
    stick_next = 1'b0;
    for (int d = 0; d < LANES; d++) begin
      trac_next[d] = 32'd0;
    end
    if (dvside[DIV_STAGES].contact) begin
      if (!dvside[DIV_STAGES].slide) begin
        stick_next = 1'b1;
        trac_next  = dvside[DIV_STAGES].stick_trac;
      end else if (dvnrm[DIV_STAGES] != 32'd0) begin
        for (int d = 0; d < LANES; d++) begin
          trac_next[d] = sat_out(dvside[DIV_STAGES].neg[d],
                                 49'(dvst[DIV_STAGES][d].quo));
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dvv[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trac_x   <= trac_next[0];
      trac_y   <= trac_next[1];
      trac_z   <= trac_next[2];
      sticking <= stick_next;
    end
  end

  `include "friction_traction_return_map_assert.svh"

  `FTRM_IMPLIES(a_sqrt_rem, sqv[SQ_STAGES], sqst[SQ_STAGES].rem <= {1'b0, sqst[SQ_STAGES].root, 1'b0}, "square root remainder too large")
  `FTRM_IMPLIES(a_div_rem, dvv[DIV_STAGES] && dvside[DIV_STAGES].contact && dvside[DIV_STAGES].slide, dvst[DIV_STAGES][0].rem < {1'b0, dvnrm[DIV_STAGES]}, "divider remainder not below norm")
  `FTRM_ALWAYS(a_stall_src, in_ready || out_valid, "pipe stalled with empty output register")

endmodule
